>>> rtl/key_matrix_scan_debounce_assert.svh
// Assertion macros shared by the key matrix scanner RTL.
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define KMS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define KMS_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/kms_pkg.sv
// Shared types and constants of the key matrix scanner.
package kms_pkg;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam int IN_COLS     = 8;
  localparam int LEVEL_W     = 8;
  localparam int CNT_W       = 8;
  localparam int LIMIT_W     = 8;
  localparam int ROWS_W      = 4;
  localparam int COLS_W      = 4;
  localparam int COL_W       = 3;
  localparam int ROW_OUT_W   = 3;
  localparam int KEY_W       = 6;
  localparam int EV_W        = 2;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = 4'd4;
  localparam logic [COLS_W-1:0]  COLS_RESET  = 4'd4;

  typedef enum logic [EV_W-1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic [ROWS_W-1:0]  rows_in_use;
    logic [COLS_W-1:0]  cols_in_use;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

>>> rtl/kms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/kms_front.sv
// Front end: accepts row scans, tracks the scanned row and queues scan requests.
module kms_front #(
  parameter int MAX_ROWS = kms_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kms_pkg::MAX_COLS_DEF,
  parameter int ENTRY_W  = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kms_pkg::cfg_t                     cfg,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kms_pkg::TDATA_IN_W-1:0]    s_tdata,
  input  kms_pkg::q_stat_t                  q_stat,
  output logic                              q_push,
  output logic [ENTRY_W-1:0]                q_data
);

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CAP = (MAX_COLS < kms_pkg::IN_COLS) ? MAX_COLS : kms_pkg::IN_COLS;

  logic [RW-1:0]              current_row;
  logic [RW-1:0]              row_next;
  logic [4:0]                 eff_rows;
  logic [4:0]                 row_inc;
  logic [kms_pkg::COLS_W-1:0] ncols;
  logic [7:0]                 base_full;
  logic                       accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // Clamp the column count to the array and the input width.
  assign ncols = (cfg.cols_in_use > kms_pkg::COLS_W'(COL_CAP)) ?
                 kms_pkg::COLS_W'(COL_CAP) : cfg.cols_in_use;

  // A row count of zero behaves like one: the row stays at zero.
  assign eff_rows = (5'(cfg.rows_in_use) > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) :
                    5'(cfg.rows_in_use);
  assign row_inc  = 5'(current_row) + 5'd1;
  assign row_next = (row_inc >= eff_rows) ? '0 : RW'(row_inc);

  assign base_full = 8'(current_row) * 8'(ncols);

  // Drop scans that examine no column; the row still advances.
  assign q_push = accept && (ncols != '0);
  assign q_data = ENTRY_W'({base_full[kms_pkg::KEY_W-1:0], ncols, current_row, s_tdata});

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
    end else if (accept) begin
      current_row <= row_next;
    end
  end

endmodule

>>> rtl/kms_queue.sv
// Two-entry request queue between the front end and the column sequencer.
module kms_queue #(
  parameter int W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     head_data,
  output kms_pkg::q_stat_t stat
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign head_data  = slot[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/kms_back.sv
// Back end: walks the columns of each queued scan, updates counters, drives results.
module kms_back #(
  parameter int MAX_ROWS = kms_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kms_pkg::MAX_COLS_DEF,
  parameter int ENTRY_W  = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kms_pkg::cfg_t                     cfg,
  input  kms_pkg::q_stat_t                  q_stat,
  input  logic [ENTRY_W-1:0]                q_data,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kms_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD_W = kms_pkg::TDATA_OUT_W - kms_pkg::ROW_OUT_W - kms_pkg::KEY_W -
                         kms_pkg::EV_W;

  // Head of queue
  logic [kms_pkg::LEVEL_W-1:0]   h_levels;
  logic [RW-1:0]                 h_row;
  logic [kms_pkg::COLS_W-1:0]    h_ncols;
  logic [kms_pkg::KEY_W-1:0]     h_base;

  // Issue stage
  logic [kms_pkg::COL_W-1:0]     col;
  logic                          a_last;
  logic                          a_fire;
  logic [AW+3:0]                 a_addr_full;
  logic [AW-1:0]                 a_addr;

  // Update stage
  logic                          r_valid;
  logic [AW-1:0]                 r_addr;
  logic                          r_pressed;
  logic [kms_pkg::KEY_W-1:0]     r_key;
  logic [kms_pkg::ROW_OUT_W-1:0] r_row;
  logic                          r_last;
  logic                          r_vld;
  logic                          r_fwd;
  logic [kms_pkg::CNT_W-1:0]     r_fwd_cnt;
  logic [kms_pkg::CNT_W-1:0]     r_cnt;
  logic [kms_pkg::CNT_W-1:0]     r_cnt_next;
  kms_pkg::ev_t                  r_ev;
  logic                          r_fire;
  logic [kms_pkg::CNT_W-1:0]     ram_rdata;
  logic [DEPTH-1:0]              entry_valid;

  // Output register
  logic                          out_free;
  logic [kms_pkg::ROW_OUT_W-1:0] m_row;
  logic [kms_pkg::KEY_W-1:0]     m_key;
  kms_pkg::ev_t                  m_ev;

  assign {h_base, h_ncols, h_row, h_levels} = q_data;

  assign a_last      = ((4'(col) + 4'd1) == h_ncols);
  assign a_addr_full = (AW+4)'(h_row) * (AW+4)'(MAX_COLS) + (AW+4)'(col);
  assign a_addr      = a_addr_full[AW-1:0];

  assign out_free = !m_tvalid || m_tready;
  assign r_fire   = r_valid && out_free;
  assign a_fire   = q_stat.valid && (!r_valid || r_fire);
  assign q_pop    = a_fire && a_last;

  // Entries never written read as zero; a write to the address being read is forwarded.
  assign r_cnt = r_fwd ? r_fwd_cnt : (r_vld ? ram_rdata : '0);

  always_comb begin
    r_cnt_next = r_cnt;
    r_ev       = kms_pkg::EV_NONE;
    if (r_pressed) begin
      if (r_cnt < cfg.debounce_limit) begin
        r_cnt_next = r_cnt + 8'd1;
        if (r_cnt_next == cfg.debounce_limit) begin
          r_ev = kms_pkg::EV_PRESS;
        end
      end
    end else if (r_cnt != '0) begin
      r_cnt_next = r_cnt - 8'd1;
      if (r_cnt_next == '0) begin
        r_ev = kms_pkg::EV_RELEASE;
      end
    end
  end

  kms_ram #(
    .WIDTH (kms_pkg::CNT_W),
    .DEPTH (DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (r_fire),
    .waddr (r_addr),
    .wdata (r_cnt_next),
    .re    (a_fire),
    .raddr (a_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      r_valid     <= 1'b0;
      m_tvalid    <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (a_fire) begin
        col <= a_last ? '0 : col + 3'd1;
      end
      if (a_fire) begin
        r_valid <= 1'b1;
      end else if (r_fire) begin
        r_valid <= 1'b0;
      end
      if (r_fire) begin
        m_tvalid            <= 1'b1;
        entry_valid[r_addr] <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      r_addr    <= a_addr;
      r_pressed <= !h_levels[col];
      r_key     <= h_base + 6'(col);
      r_row     <= kms_pkg::ROW_OUT_W'(h_row);
      r_last    <= a_last;
      r_vld     <= entry_valid[a_addr];
      r_fwd     <= r_fire && (r_addr == a_addr);
      r_fwd_cnt <= r_cnt_next;
    end
    if (r_fire) begin
      m_row   <= r_row;
      m_key   <= r_key;
      m_ev    <= r_ev;
      m_tlast <= r_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, m_ev, m_key, m_row};

endmodule

>>> rtl/key_matrix_scan_debounce.sv
// Top level of the key matrix scanner with per-key debounce counters.
//
// Input stream (s_*): one request per row scan; s_tdata carries the column levels
// read while the current row is driven low, bit c for column c, low meaning pressed.
// Output stream (m_*): one result per examined column, in column order, with tlast
// on the final column of the row. Scans that examine no column give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 debounce limit,
// 1 rows in use, 2 columns in use); write only while the block is idle.
// Path: an accepted scan waits in the queue; the column sequencer then reads each column's
// counter, updates it and loads the result into the output register, in column order.
// Throughput: one result per cycle while the receiver keeps tready high; a scan examines
// up to 8 columns. The column sequencer, with one counter read-modify-write per cycle, sets the rate.
// A two-entry queue lets the front keep accepting scans while the back is busy.
// Reset: control state clears at once; every counter reads as zero until written
// through per-entry valid bits, so no clearing pass is needed. Row and registers
// return to their defaults (limit 5, 4 rows, 4 columns).
// Receiver stall: the output register holds, the sequencer halts, the queue fills
// and s_tready falls once two scans are waiting.
module key_matrix_scan_debounce #(
  parameter int MAX_ROWS = kms_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = kms_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kms_pkg::TDATA_IN_W-1:0]   s_tdata,   // [7:0] column_levels
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kms_pkg::TDATA_OUT_W-1:0]  m_tdata,   // [2:0] row_scanned, [8:3] key_index,
                                                      // [10:9] event_res, [15:11] zero
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "key_matrix_scan_debounce_assert.svh"

  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // Queue entry: levels, row, column count, key index base.
  localparam int ENTRY_W = kms_pkg::LEVEL_W + RW + kms_pkg::COLS_W + kms_pkg::KEY_W;

  kms_pkg::cfg_t     cfg;
  kms_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_head;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit <= kms_pkg::LIMIT_RESET;
      cfg.rows_in_use    <= kms_pkg::ROWS_RESET;
      cfg.cols_in_use    <= kms_pkg::COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kms_pkg::REG_LIMIT: cfg.debounce_limit <= cfg_data;
        kms_pkg::REG_ROWS:  cfg.rows_in_use    <= cfg_data[kms_pkg::ROWS_W-1:0];
        kms_pkg::REG_COLS:  cfg.cols_in_use    <= cfg_data[kms_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept scans, advance the row, queue non-empty scans.
  kms_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ENTRY_W  (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Hold up to two scans between front and back.
  kms_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  // Walk columns, update the counter store, drive the output register.
  kms_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .q_data   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The front never pushes into a full queue.
  `KMS_ASSERT_IMP(a_no_overflow, clk, rst, q_push, !q_stat.full, "push into full queue")
  // The back never pops an empty queue.
  `KMS_ASSERT_IMP(a_no_underflow, clk, rst, q_pop, q_stat.valid, "pop from empty queue")
  // A pushed scan is waiting in the following cycle.
  `KMS_ASSERT_NXT(a_push_seen, clk, rst, q_push, q_stat.valid, "pushed scan lost")
  // The counter update only ever reports none, press or release.
  `KMS_ASSERT_IMP(a_ev_code, clk, rst, m_tvalid, m_tdata[10:9] != 2'b11, "bad event code")

endmodule
